### hdl/lbbe_pkg.sv
package lbbe_pkg;

    localparam int NUM_BLOCKS_DEF = 32;
    localparam int ID_W           = 5;
    localparam int BYTES_W        = 32;
    localparam int USED_W         = 37;
    localparam int BUDGET_W       = 40;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 40'd4000000000;

    typedef enum logic {
        ACT_ACCESS  = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        EV_TOUCH   = 3'd0,
        EV_LOAD    = 3'd1,
        EV_EVICT   = 3'd2,
        EV_RELEASE = 3'd3,
        EV_ERROR   = 3'd4
    } t_event;

    // shared adder operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_GT
    } t_alu_op;

    // recency order updates
    typedef enum logic [1:0] {
        ORD_NONE,
        ORD_TOUCH,
        ORD_LOAD,
        ORD_DROP
    } t_ord_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD_CHK,
        ST_EVICT_RD,
        ST_EVICT_SUB,
        ST_EVICT_CHK,
        ST_REL_SUB
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [ID_W-1:0]     block_id;
        logic [BYTES_W-1:0]  block_bytes;
    } t_in_word;

    typedef struct packed {
        t_event              event_res;
        logic [ID_W-1:0]     event_block;
        logic [USED_W-1:0]   bytes_in_use;
        logic                last;
    } t_out_word;

endpackage

### hdl/lbbe_alu.sv
module lbbe_alu (
    input  lbbe_pkg::t_alu_op                 i_op,
    input  logic [lbbe_pkg::BUDGET_W-1:0]     i_a,
    input  logic [lbbe_pkg::BUDGET_W-1:0]     i_b,
    output logic [lbbe_pkg::BUDGET_W-1:0]     o_res,
    output logic                              o_gt
);
    import lbbe_pkg::*;

    logic                  w_sub;
    logic [BUDGET_W-1:0]   w_bx;
    logic [BUDGET_W:0]     w_sum;
    logic                  w_no_borrow;

    // one adder: a + b, or a + ~b + 1 for subtract and compare
    assign w_sub       = (i_op != ALU_ADD);
    assign w_bx        = w_sub ? ~i_b : i_b;
    assign w_sum       = {1'b0, i_a} + {1'b0, w_bx} + (BUDGET_W+1)'(w_sub);
    assign w_no_borrow = w_sum[BUDGET_W];

    assign o_gt = w_no_borrow && (w_sum[BUDGET_W-1:0] != '0);

    always_comb begin
        case (i_op)
            ALU_ADD: o_res = w_sum[BUDGET_W-1:0];
            ALU_SUB: o_res = w_no_borrow ? w_sum[BUDGET_W-1:0] : '0;   // floor at zero
            default: o_res = w_sum[BUDGET_W-1:0];
        endcase
    end

endmodule

### hdl/lbbe_size_mem.sv
module lbbe_size_mem #(
    parameter  int NUM_BLOCKS = lbbe_pkg::NUM_BLOCKS_DEF,
    localparam int IDX_W      = $clog2(NUM_BLOCKS)
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [IDX_W-1:0]                 i_waddr,
    input  logic [lbbe_pkg::BYTES_W-1:0]     i_wdata,
    input  logic                             i_re,
    input  logic [IDX_W-1:0]                 i_raddr,
    output logic [lbbe_pkg::BYTES_W-1:0]     o_rdata
);
    import lbbe_pkg::*;

    logic [BYTES_W-1:0] r_mem [NUM_BLOCKS];
    logic [BYTES_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/lbbe_order.sv
module lbbe_order #(
    parameter  int NUM_BLOCKS = lbbe_pkg::NUM_BLOCKS_DEF,
    localparam int IDX_W      = $clog2(NUM_BLOCKS),
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbbe_pkg::t_ord_op    i_op,
    input  logic [IDX_W-1:0]     i_blk,
    output logic                 o_blk_resident,
    output logic [IDX_W-1:0]     o_tail,
    output logic                 o_empty
);
    import lbbe_pkg::*;

    // rank per block (0 = most recent) and block per position
    logic [NUM_BLOCKS-1:0] r_resident, n_resident;
    logic [IDX_W-1:0]      r_rank  [NUM_BLOCKS];
    logic [IDX_W-1:0]      n_rank  [NUM_BLOCKS];
    logic [IDX_W-1:0]      r_order [NUM_BLOCKS];
    logic [IDX_W-1:0]      n_order [NUM_BLOCKS];
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      w_rank;
    logic [IDX_W-1:0]      w_tail_ix;

    assign w_rank         = r_rank[i_blk];
    assign w_tail_ix      = IDX_W'(r_count - 1'b1);
    assign o_blk_resident = r_resident[i_blk];
    assign o_tail         = r_order[w_tail_ix];
    assign o_empty        = (r_count == '0);

    always_comb begin
        n_resident = r_resident;
        n_rank     = r_rank;
        n_order    = r_order;
        n_count    = r_count;
        unique case (i_op)
            ORD_TOUCH: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (r_resident[i] && (r_rank[i] < w_rank)) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[i_blk] = '0;
                for (int p = 1; p < NUM_BLOCKS; p++) begin
                    if (IDX_W'(p) <= w_rank) begin
                        n_order[p] = r_order[p-1];
                    end
                end
                n_order[0] = i_blk;
            end
            ORD_LOAD: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (r_resident[i]) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[i_blk] = '0;
                for (int p = 1; p < NUM_BLOCKS; p++) begin
                    n_order[p] = r_order[p-1];
                end
                n_order[0]        = i_blk;
                n_resident[i_blk] = 1'b1;
                n_count           = r_count + 1'b1;
            end
            ORD_DROP: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (r_resident[i] && (r_rank[i] > w_rank)) begin
                        n_rank[i] = r_rank[i] - 1'b1;
                    end
                end
                for (int p = 0; p < NUM_BLOCKS - 1; p++) begin
                    if (IDX_W'(p) >= w_rank) begin
                        n_order[p] = r_order[p+1];
                    end
                end
                n_resident[i_blk] = 1'b0;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            ORD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resident <= '0;
            r_count    <= '0;
        end else begin
            r_resident <= n_resident;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank  <= n_rank;
        r_order <= n_order;
    end

endmodule

### hdl/lru_byte_budget_block_evictor_unit.sv
// LRU residency tracker for up to NUM_BLOCKS memory blocks under a 40-bit byte budget.
// Each input word is one request: access (touch a resident block, or load an absent one)
// or release. Every request gives one or more result words, the final one flagged by last:
// touch, release and error give exactly one; a load gives the load word followed by one
// evict word per block dropped from the least-recent end while usage exceeds the budget
// (the block just loaded may be among them). bytes_in_use on each word is the total after
// that event. The block takes one request at a time and holds o_in_stall high until its
// last result word is in the output register. The single 40-bit adder/comparator is
// shared by the usage update and the budget check, and the block size store is read
// through a register before each subtraction. The budget register may be written only
// while the block is idle; the new value takes effect with the next request. Block ids
// at or above NUM_BLOCKS return an error.
module lru_byte_budget_block_evictor_unit #(
    parameter int NUM_BLOCKS = lbbe_pkg::NUM_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lbbe_pkg::BUDGET_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lbbe_pkg::t_in_word                i_in_word,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lbbe_pkg::t_out_word               o_out_word
);
    import lbbe_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic [BUDGET_W-1:0]  r_budget;
    t_in_word             r_in;
    logic [USED_W-1:0]    r_used, n_used;
    logic [IDX_W-1:0]     r_victim, n_victim;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_word, n_out_word;

    // request classification
    logic                 w_id_ok;
    logic [IDX_W-1:0]     w_id_ix;
    logic                 w_is_err;
    logic                 w_is_rel;
    logic                 w_is_touch;
    logic                 w_out_free;

    // recency order unit
    t_ord_op              w_ord_op;
    logic [IDX_W-1:0]     w_ord_blk;
    logic                 w_blk_res;
    logic [IDX_W-1:0]     w_tail;
    logic                 w_ord_empty;

    // size store
    logic                 w_mem_we;
    logic                 w_mem_re;
    logic [IDX_W-1:0]     w_mem_raddr;
    logic [BYTES_W-1:0]   w_mem_rdata;

    // shared adder
    t_alu_op              w_alu_op;
    logic [BUDGET_W-1:0]  w_alu_a;
    logic [BUDGET_W-1:0]  w_alu_b;
    logic [BUDGET_W-1:0]  w_alu_res;
    logic                 w_alu_gt;

    // result being issued this cycle
    logic                 w_emit;
    t_out_word            w_emit_word;

    lbbe_order #(.NUM_BLOCKS(NUM_BLOCKS)) u_order (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_ord_op),
        .i_blk          (w_ord_blk),
        .o_blk_resident (w_blk_res),
        .o_tail         (w_tail),
        .o_empty        (w_ord_empty)
    );

    lbbe_size_mem #(.NUM_BLOCKS(NUM_BLOCKS)) u_size_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_id_ix),
        .i_wdata (r_in.block_bytes),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    lbbe_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res),
        .o_gt  (w_alu_gt)
    );

    // only ids below NUM_BLOCKS have storage
    assign w_id_ok    = (32'(r_in.block_id) < NUM_BLOCKS);
    assign w_id_ix    = IDX_W'(r_in.block_id);
    assign w_is_err   = !w_id_ok || ((r_in.action == ACT_RELEASE) && !w_blk_res);
    assign w_is_rel   = !w_is_err && (r_in.action == ACT_RELEASE);
    assign w_is_touch = !w_is_err && (r_in.action == ACT_ACCESS) && w_blk_res;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_alu_a    = BUDGET_W'(r_used);
    assign o_in_stall = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_is_err || w_is_touch) begin
                    if (w_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (w_is_rel) begin
                    n_state = ST_REL_SUB;
                end else begin
                    n_state = ST_LOAD_CHK;
                end
            end
            ST_LOAD_CHK: begin
                if (w_out_free) begin
                    n_state = w_alu_gt ? ST_EVICT_RD : ST_IDLE;
                end
            end
            ST_EVICT_RD: begin
                n_state = ST_EVICT_SUB;
            end
            ST_EVICT_SUB: begin
                n_state = ST_EVICT_CHK;
            end
            ST_EVICT_CHK: begin
                if (w_out_free) begin
                    n_state = (w_alu_gt && !w_ord_empty) ? ST_EVICT_RD : ST_IDLE;
                end
            end
            ST_REL_SUB: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        n_used      = r_used;
        n_victim    = r_victim;
        w_ord_op    = ORD_NONE;
        w_ord_blk   = w_id_ix;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_raddr = w_id_ix;
        w_alu_op    = ALU_GT;
        w_alu_b     = r_budget;
        w_emit      = 1'b0;
        w_emit_word = '{event_res: EV_ERROR, event_block: r_in.block_id,
                        bytes_in_use: r_used, last: 1'b1};
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_DECIDE: begin
                if (w_is_err) begin
                    w_emit = w_out_free;
                end else if (w_is_touch) begin
                    w_emit                = w_out_free;
                    w_emit_word.event_res = EV_TOUCH;
                    if (w_out_free) begin
                        w_ord_op = ORD_TOUCH;
                    end
                end else if (w_is_rel) begin
                    // fetch the stored size for the subtraction
                    w_mem_re = 1'b1;
                end else begin
                    // load: add the size, block becomes most recent
                    w_ord_op = ORD_LOAD;
                    w_mem_we = 1'b1;
                    w_alu_op = ALU_ADD;
                    w_alu_b  = BUDGET_W'(r_in.block_bytes);
                    n_used   = w_alu_res[USED_W-1:0];
                end
            end
            ST_LOAD_CHK: begin
                w_emit                = w_out_free;
                w_emit_word.event_res = EV_LOAD;
                w_emit_word.last      = !w_alu_gt;
            end
            ST_EVICT_RD: begin
                // least recent block and its size
                n_victim    = w_tail;
                w_mem_re    = 1'b1;
                w_mem_raddr = w_tail;
            end
            ST_EVICT_SUB: begin
                w_ord_op  = ORD_DROP;
                w_ord_blk = r_victim;
                w_alu_op  = ALU_SUB;
                w_alu_b   = BUDGET_W'(w_mem_rdata);
                n_used    = w_alu_res[USED_W-1:0];
            end
            ST_EVICT_CHK: begin
                w_emit                  = w_out_free;
                w_emit_word.event_res   = EV_EVICT;
                w_emit_word.event_block = ID_W'(r_victim);
                w_emit_word.last        = !(w_alu_gt && !w_ord_empty);
            end
            ST_REL_SUB: begin
                w_alu_op                 = ALU_SUB;
                w_alu_b                  = BUDGET_W'(w_mem_rdata);
                w_emit                   = w_out_free;
                w_emit_word.event_res    = EV_RELEASE;
                w_emit_word.bytes_in_use = w_alu_res[USED_W-1:0];
                if (w_out_free) begin
                    w_ord_op = ORD_DROP;
                    n_used   = w_alu_res[USED_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // output register: a new word loads whenever the slot is free
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_word  = w_emit_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_budget    <= BUDGET_RESET;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_in <= i_in_word;
        end
        r_victim   <= n_victim;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // only a load or an eviction can be followed by more words
    a_last_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.last) |->
            (r_out_word.event_res == EV_LOAD || r_out_word.event_res == EV_EVICT))
        else $error("non-final word on a single-word event");

    // eviction never starts from an empty recency list
    a_evict_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT_RD) |-> !w_ord_empty)
        else $error("eviction with no resident block");

    // an eviction never raises usage
    a_evict_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT_SUB) |=> (r_used <= $past(r_used)))
        else $error("usage grew on eviction");

    // the block shows busy right after it takes a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !$past(w_emit)))
        else $error("request not held busy after accept");

endmodule

### tb/sv/lbbe_event_checker.sv
`timescale 1ns / 100ps

module lbbe_event_checker #(
    parameter int NUM_BLOCKS = lbbe_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lbbe_pkg::BUDGET_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  lbbe_pkg::t_in_word            i_in_word,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  lbbe_pkg::t_out_word           i_out_word,
    output int                            o_fail_count,
    output int                            o_pending
);
    import lbbe_pkg::*;

    localparam int PRINT_CAP = 40;

    // shadow of the residency state
    logic [NUM_BLOCKS-1:0] held;
    logic [BYTES_W-1:0]    held_bytes [NUM_BLOCKS];
    logic [ID_W-1:0]       age_rank [NUM_BLOCKS];
    int                    held_count;
    logic [USED_W-1:0]     used_total;
    logic [BUDGET_W-1:0]   budget;

    t_out_word due_words[$];
    int        mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic void post_event(input t_event ev, input int blk);
        t_out_word e;
        e.event_res    = ev;
        e.event_block  = blk[ID_W-1:0];
        e.bytes_in_use = used_total;
        e.last         = 1'b0;
        due_words.push_back(e);
    endfunction

    function automatic void drop_block(input int b);
        logic [ID_W-1:0] r;
        r = age_rank[b];
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (held[i] && age_rank[i] > r) begin
                age_rank[i] = age_rank[i] - 1'b1;
            end
        end
        used_total = (used_total >= held_bytes[b]) ? used_total - held_bytes[b] : '0;
        held[b] = 1'b0;
        if (held_count > 0) begin
            held_count--;
        end
    endfunction

    // one request in, its event words appended to due_words
    function automatic void apply_request(input t_in_word w);
        int              b;
        int              victim;
        bit              stuck;
        logic [ID_W-1:0] r;
        b = int'(w.block_id);
        if (b >= NUM_BLOCKS) begin
            post_event(EV_ERROR, b);
        end else if (w.action == ACT_RELEASE) begin
            if (held[b]) begin
                drop_block(b);
                post_event(EV_RELEASE, b);
            end else begin
                post_event(EV_ERROR, b);
            end
        end else if (held[b]) begin
            r = age_rank[b];
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (held[i] && age_rank[i] < r) begin
                    age_rank[i] = age_rank[i] + 1'b1;
                end
            end
            age_rank[b] = '0;
            post_event(EV_TOUCH, b);
        end else begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (held[i]) begin
                    age_rank[i] = age_rank[i] + 1'b1;
                end
            end
            held[b]       = 1'b1;
            held_bytes[b] = w.block_bytes;
            age_rank[b]   = '0;
            held_count++;
            used_total    = used_total + w.block_bytes;
            post_event(EV_LOAD, b);
            // evict from the old end until usage fits
            stuck = 1'b0;
            while (used_total > budget && held_count > 0 && !stuck) begin
                victim = -1;
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (held[i] && age_rank[i] == held_count - 1) begin
                        victim = i;
                    end
                end
                if (victim < 0) begin
                    stuck = 1'b1;
                end else begin
                    drop_block(victim);
                    post_event(EV_EVICT, victim);
                end
            end
        end
        // newest queued word closes this request
        due_words[due_words.size() - 1].last = 1'b1;
    endfunction

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            report($sformatf("result word with none pending: ev %0d blk %0d used %0d last %0d",
                             got.event_res, got.event_block, got.bytes_in_use, got.last));
        end else begin
            want = due_words.pop_front();
            if (got.event_res !== want.event_res)
                report($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
            if (got.event_block !== want.event_block)
                report($sformatf("event_block got %0d want %0d",
                                 got.event_block, want.event_block));
            if (got.bytes_in_use !== want.bytes_in_use)
                report($sformatf("bytes_in_use got %0d want %0d",
                                 got.bytes_in_use, want.bytes_in_use));
            if (got.last !== want.last)
                report($sformatf("last got %0d want %0d", got.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held       = '0;
            held_count = 0;
            used_total = '0;
            budget     = BUDGET_RESET;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                budget = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_word);
            end
        end
        o_pending    <= due_words.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/sv/tb_lru_byte_budget_block_evictor_unit.sv
`timescale 1ns / 100ps

module tb_lru_byte_budget_block_evictor_unit;
    import lbbe_pkg::*;

    localparam int IDLE_LIMIT    = 4000;  // cycles with no word moving
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;

    localparam logic [BUDGET_W-1:0] BUDGET_MAX = {BUDGET_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [BUDGET_W-1:0] cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    t_in_word            in_word;
    logic                out_valid;
    logic                out_stall;
    t_out_word           out_word;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int sent        = 0;
    int send_mode   = 0;
    bit hold_out    = 1'b0;   // asks the receiver for one long hold-off

    lru_byte_budget_block_evictor_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // watches both channels, predicts event words and compares them
    lbbe_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: any moving word or config write resets the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver side: stretches of no stall, light and heavy stalling,
    // occasional long bursts, plus one long hold-off on request
    initial begin : out_side
        int mode;
        int mode_left;
        int burst_left;
        mode       = 0;
        mode_left  = 0;
        burst_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(posedge clk);
            if (burst_left > 0) begin
                burst_left--;
                out_stall <= 1'b1;
            end else if (hold_out) begin
                // sender keeps offering meanwhile, so the block backs up
                hold_out   = 1'b0;
                burst_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: begin
                        out_stall <= 1'b0;
                    end
                    1: begin
                        if ($urandom_range(0, 49) == 0) begin
                            burst_left = $urandom_range(8, 40);
                            out_stall <= 1'b1;
                        end else begin
                            out_stall <= ($urandom_range(0, 3) == 0);
                        end
                    end
                    default: begin
                        out_stall <= $urandom_range(0, 1);
                    end
                endcase
            end
        end
    end

    // idle cycles before the next word, mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        case (send_mode)
            0: return 0;
            1: return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            default: return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) :
                                                       $urandom_range(10, 60);
        endcase
    endfunction

    // offer one request word and wait for it to be taken
    task automatic offer(input t_in_word w);
        int gap;
        if (sent % 16 == 0) begin
            send_mode = $urandom_range(0, 2);
        end
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic request(input t_action a, input int id, input logic [BYTES_W-1:0] n);
        t_in_word w;
        w.action      = a;
        w.block_id    = id[ID_W-1:0];
        w.block_bytes = n;
        offer(w);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // budget writes only once the block is idle
    task automatic set_budget(input logic [BUDGET_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random block size: narrow for the small budget, else full range with edges
    function automatic logic [BYTES_W-1:0] pick_bytes(input bit wide);
        int r;
        r = $urandom_range(0, 9);
        if (!wide) begin
            return (r == 0) ? '0 : $urandom_range(1, 2000);
        end
        case (r)
            0:       return '0;
            1:       return {BYTES_W{1'b1}};
            2:       return 32'd1 << $urandom_range(0, BYTES_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // random request, half of them on a few hot blocks so touches and releases hit
    task automatic random_requests(input int count, input bit wide);
        t_action a;
        int      id;
        repeat (count) begin
            a  = ($urandom_range(0, 9) < 3) ? ACT_RELEASE : ACT_ACCESS;
            id = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31);
            request(a, id, pick_bytes(wide));
        end
    endtask

    initial begin : stimulus
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset budget
        request(ACT_RELEASE, 5, 32'd0);              // release of an absent block
        request(ACT_ACCESS, 0, 32'd0);               // zero-size load
        request(ACT_ACCESS, 0, 32'hFFFF_FFFF);       // touch, size ignored
        request(ACT_ACCESS, 31, 32'hFFFF_FFFF);      // over budget, new block evicted too
        request(ACT_ACCESS, 1, 32'd3000000000);
        request(ACT_ACCESS, 2, 32'd1000000000);      // exactly at budget, no eviction
        request(ACT_ACCESS, 1, 32'd7);               // touch moves block 1 to front
        request(ACT_ACCESS, 3, 32'd1);               // one byte over, oldest goes
        request(ACT_RELEASE, 3, 32'hFFFF_FFFF);      // release frees the stored size
        request(ACT_RELEASE, 3, 32'd0);              // now absent
        request(ACT_ACCESS, 4, 32'd0);
        request(ACT_ACCESS, 5, 32'd0);
        request(ACT_RELEASE, 1, 32'd0);
        request(ACT_ACCESS, 4, 32'd9);

        set_budget('0);
        request(ACT_ACCESS, 6, 32'd1);               // everything, itself included, evicted
        request(ACT_ACCESS, 7, 32'd0);               // zero bytes still fit a zero budget
        request(ACT_RELEASE, 7, 32'd5);

        set_budget(BUDGET_MAX);
        for (int i = 8; i < 12; i++) begin
            request(ACT_ACCESS, i, 32'hFFFF_FFFF);
        end
        request(ACT_RELEASE, 9, 32'd0);
        request(ACT_RELEASE, 31, 32'hFFFF_FFFF);

        // no eviction possible; long receiver hold-off while words keep coming
        hold_out = 1'b1;
        random_requests(25, 1'b1);

        // zero budget: nonzero loads clear the whole set
        set_budget('0);
        random_requests(20, 1'b1);

        // small budget with small blocks: partial evictions
        set_budget(40'd5000);
        random_requests(30, 1'b0);

        // fill the set, then one load that drops every block
        set_budget(BUDGET_MAX);
        for (int i = 0; i < 31; i++) begin
            request(ACT_ACCESS, i, pick_bytes(1'b1));
        end
        request(ACT_RELEASE, 31, 32'd0);
        set_budget('0);
        request(ACT_ACCESS, 31, $urandom_range(1, 1000));

        // mid-range budgets with full-range sizes
        set_budget(40'd8589934592);
        random_requests(20, 1'b1);
        set_budget({8'($urandom_range(1, 15)), $urandom});
        random_requests(20, 1'b1);

        drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/lbbe_pkg.sv
hdl/lbbe_alu.sv
hdl/lbbe_size_mem.sv
hdl/lbbe_order.sv
hdl/lru_byte_budget_block_evictor_unit.sv
tb/sv/lbbe_event_checker.sv
tb/sv/tb_lru_byte_budget_block_evictor_unit.sv
